// File: design/dedup_fifo_with_ids_defines.svh
// Assertion macros shared by the deduplicating queue.
// Each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef DEDUP_FIFO_WITH_IDS_DEFINES_SVH
`define DEDUP_FIFO_WITH_IDS_DEFINES_SVH

// Same-cycle implication
`define DFIFO_CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DFIFO_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dfifo_pkg.sv
package dfifo_pkg;

    // Request operation
    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [63:0] name_key;
        logic [63:0] type_key;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] entry_id;
        logic [63:0] out_name;
        logic [63:0] out_type;
    } t_out_item;

    // One stored queue entry
    typedef struct packed {
        logic [63:0] e_name;
        logic [63:0] e_type;
        logic [15:0] e_id;
    } t_entry;

    localparam int          ENTRY_W  = $bits(t_entry);
    localparam logic [15:0] ID_RESET = 16'd1;

endpackage

// File: design/dfifo_ram.sv
module dfifo_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dfifo_ctrl.sv
module dfifo_ctrl
    import dfifo_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_in_item  i_req,
    output logic      o_res_valid,
    input  logic      i_res_take,
    output t_out_item o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [15:0]     r_next_id, n_next_id;
    t_in_item        r_req, n_req;
    logic [AW-1:0]   r_scan_addr, n_scan_addr;
    logic [CW-1:0]   r_scan_n, n_scan_n;
    t_out_item       r_res, n_res;

    logic [AW-1:0]      raddr;
    logic               we;
    t_entry             wentry;
    logic [ENTRY_W-1:0] rdata_raw;
    t_entry             rentry;
    logic               key_hit;
    t_out_item          fresh_res;

    // Advance a ring index, wrapping at the queue depth
    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] idx);
        logic [AW-1:0] nxt;
        nxt = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    // Entry storage: one write port at the tail, one read port for scan and pop
    dfifo_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_tail),
        .i_wdata(wentry),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    assign rentry = t_entry'(rdata_raw);
    assign wentry = '{e_name: r_req.name_key, e_type: r_req.type_key, e_id: r_next_id};

    // Compare the entry read last cycle against the pending keys
    assign key_hit = (rentry.e_name == r_req.name_key) && (rentry.e_type == r_req.type_key);

    // Read the head on accept, then walk forward one entry per cycle
    assign raddr = (r_state == S_IDLE) ? r_head : f_adv(r_scan_addr);

    // Result of a push that found no duplicate
    always_comb begin
        fresh_res.out_name = r_req.name_key;
        fresh_res.out_type = r_req.type_key;
        if (r_count == CW'(DEPTH)) begin
            fresh_res.status   = ST_FULL;
            fresh_res.entry_id = '0;
        end else begin
            fresh_res.status   = ST_OK;
            fresh_res.entry_id = r_next_id;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_req       = r_req;
        n_scan_addr = r_scan_addr;
        n_scan_n    = r_scan_n;
        n_res       = r_res;
        we          = 1'b0;
        o_res_valid = 1'b0;
        o_req_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                n_scan_addr = r_head;
                n_scan_n    = '0;
                if (i_req_valid) begin
                    n_req = i_req;
                    if (i_req.func == FUNC_PUSH) begin
                        if (r_count == '0) begin
                            // Empty queue cannot hold a duplicate and cannot be full
                            n_res.status   = ST_OK;
                            n_res.entry_id = r_next_id;
                            n_res.out_name = i_req.name_key;
                            n_res.out_type = i_req.type_key;
                            n_state        = S_FINISH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status   = ST_EMPTY;
                            n_res.entry_id = '0;
                            n_res.out_name = '0;
                            n_res.out_type = '0;
                            n_state        = S_FINISH;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                end
            end

            S_SCAN: begin
                n_scan_addr = raddr;
                n_scan_n    = CW'(r_scan_n + 1'b1);
                if (key_hit) begin
                    n_res.status   = ST_DUP;
                    n_res.entry_id = '0;
                    n_res.out_name = r_req.name_key;
                    n_res.out_type = r_req.type_key;
                    n_state        = S_FINISH;
                end else if (CW'(r_scan_n + 1'b1) == r_count) begin
                    n_res   = fresh_res;
                    n_state = S_FINISH;
                end
            end

            S_POP_RD: begin
                n_res.status   = ST_OK;
                n_res.entry_id = rentry.e_id;
                n_res.out_name = rentry.e_name;
                n_res.out_type = rentry.e_type;
                n_state        = S_FINISH;
            end

            S_FINISH: begin
                // Commit queue updates once the result is handed over; the next
                // scan starts after this write, so no read can see stale data
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                    if (r_res.status == ST_OK) begin
                        if (r_req.func == FUNC_PUSH) begin
                            we        = 1'b1;
                            n_tail    = f_adv(r_tail);
                            n_count   = CW'(r_count + 1'b1);
                            n_next_id = r_next_id + 16'd1;
                        end else begin
                            n_head  = f_adv(r_head);
                            n_count = CW'(r_count - 1'b1);
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_next_id <= ID_RESET;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_scan_addr <= n_scan_addr;
        r_scan_n    <= n_scan_n;
        r_res       <= n_res;
    end

endmodule

// File: design/dedup_fifo_with_ids.sv
// Channel   Direction  Signals                          Payload
// request   in         i_req_valid / o_req_stall        i_req (t_in_item)
// response  out        o_rsp_valid / i_rsp_stall        o_rsp (t_out_item)
//
// A push reads and compares the N stored entries in turn (one RAM read per entry
// scanned, ending early on a match); a pop reads the head entry, an empty pop does not.
// The scan rate is set by the single read port of the entry RAM.
// One transaction is in flight at a time; the next is taken once the result
// moves into the output register, which holds it while the response side stalls.
// Synchronous active-low reset empties the queue and sets the running id to 1.
`include "dedup_fifo_with_ids_defines.svh"

module dedup_fifo_with_ids
    import dfifo_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_in_item  i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_stall,
    output t_out_item o_rsp
);

    logic      res_valid;
    logic      res_take;
    t_out_item res;
    logic      r_rsp_valid, n_rsp_valid;
    t_out_item r_rsp;

    dfifo_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res)
    );

    // Load the output register when it is empty or being drained
    assign res_take    = res_valid && (!r_rsp_valid || !i_rsp_stall);
    assign n_rsp_valid = res_take || (r_rsp_valid && i_rsp_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_rsp <= res;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // A taken request keeps the controller busy on the following cycle
    `DFIFO_CHK_NEXT(a_busy_after_accept, i_req_valid && !o_req_stall, o_req_stall, "request accepted but controller not busy")

    // A handed-over result always shows up in the output register
    `DFIFO_CHK_NEXT(a_take_loads_rsp, res_take, r_rsp_valid, "result taken but response not valid")

    // Rejected and empty results carry no id
    `DFIFO_CHK_SAME(a_reject_no_id, r_rsp_valid && (r_rsp.status != ST_OK), r_rsp.entry_id == 16'd0, "non-ok result with nonzero id")

endmodule
